// ===== hw/rtl/well512_random_generator_core_assert.svh =====
// Assertion macros for the WELL512 generator core.
// Used by the top level only; clk_i and rst_ni must be in scope where applied.
`ifndef WELL512_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define WELL512_RANDOM_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define W512_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define W512_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define W512_ASSERT(lbl, prop, msg)
`define W512_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hw/rtl/w512_pkg.sv =====
// Shared types and constants of the WELL512 generator core.
// No dependencies; used by every module of the block.
package w512_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned PoolDepth = 16;
  localparam int unsigned PosW      = 4;

  // Pool taps relative to the current position (the ring keeps position at cell 0).
  localparam int unsigned TapY    = 13;
  localparam int unsigned TapZ    = 9;
  localparam int unsigned TapPrev = 15;

  localparam logic [WordW-1:0] SeedMult   = 32'd1812433253;
  localparam logic [WordW-1:0] TemperMask = 32'hDA44_2D24;

  typedef logic [WordW-1:0] word_t;

  // Shift controls for the row of pool cells.
  typedef struct packed {
    logic gen;   // take the word from the lower neighbour
    logic fill;  // take the word from the upper neighbour
  } shift_t;

endpackage

// ===== hw/rtl/w512_cell.sv =====
// One pool cell: a 32-bit state word that shifts towards either neighbour.
// Depends on w512_pkg.
module w512_cell (
  input  logic             clk_i,
  input  w512_pkg::shift_t shift_i,
  input  w512_pkg::word_t  from_lo_i,
  input  w512_pkg::word_t  from_hi_i,
  output w512_pkg::word_t  word_o
);

  w512_pkg::word_t word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i.gen) begin
      word_q <= from_lo_i;
    end else if (shift_i.fill) begin
      word_q <= from_hi_i;
    end
  end

  assign word_o = word_q;

endmodule

// ===== hw/rtl/w512_mix.sv =====
// Generation mixing network: four pool taps in, two rewritten words out.
// Depends on w512_pkg.
module w512_mix (
  input  w512_pkg::word_t x_i,
  input  w512_pkg::word_t y_i,
  input  w512_pkg::word_t z_i,
  input  w512_pkg::word_t prev_i,
  output w512_pkg::word_t fresh_o,
  output w512_pkg::word_t out_o
);

  w512_pkg::word_t mix;
  w512_pkg::word_t zt;
  w512_pkg::word_t fresh;
  w512_pkg::word_t tempered;

  always_comb begin
    mix      = x_i ^ y_i ^ (x_i << 16) ^ (y_i << 15);
    zt       = z_i ^ (z_i >> 11);
    fresh    = mix ^ zt;
    tempered = fresh ^ ((fresh << 5) & w512_pkg::TemperMask);
  end

  assign fresh_o = fresh;
  assign out_o   = prev_i ^ mix ^ tempered ^ (prev_i << 2) ^ (mix << 18) ^ (zt << 28);

endmodule

// ===== hw/rtl/w512_seed.sv =====
// Seeding sequencer: produces one pool word per cycle from the seed recurrence.
// Depends on w512_pkg.
module w512_seed (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  w512_pkg::word_t  seed_i,
  output logic             busy_o,
  output w512_pkg::word_t  value_o
);

  logic                      fill_q, fill_d;
  logic [w512_pkg::PosW-1:0] count_q, count_d;
  w512_pkg::word_t           prev_q, prev_d;
  w512_pkg::word_t           mixed;
  w512_pkg::word_t           prod;
  w512_pkg::word_t           value;

  always_comb begin
    mixed = prev_q ^ (prev_q >> 30);
    prod  = mixed * w512_pkg::SeedMult;
    // The first word of a fill is the seed itself.
    if (count_q == '0) begin
      value = prev_q;
    end else begin
      value = prod + {{(w512_pkg::WordW - w512_pkg::PosW){1'b0}}, count_q};
    end
  end

  always_comb begin
    fill_d  = fill_q;
    count_d = count_q;
    prev_d  = prev_q;
    if (start_i) begin
      fill_d  = 1'b1;
      count_d = '0;
      prev_d  = seed_i;
    end else if (fill_q) begin
      prev_d  = value;
      count_d = count_q + 1'b1;
      if (count_q == w512_pkg::PosW'(w512_pkg::PoolDepth - 1)) begin
        fill_d = 1'b0;
      end
    end
  end

  // Reset starts a fill with a zero seed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= 1'b1;
      count_q <= '0;
      prev_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      count_q <= count_d;
      prev_q  <= prev_d;
    end
  end

  assign busy_o  = fill_q;
  assign value_o = value;

endmodule

// ===== hw/rtl/well512_random_generator_core.sv =====
// WELL512 generator core: a ring of sixteen pool cells, the mixing network,
// the seeding sequencer and the result register. Depends on w512_pkg.
// Generate: result registered in the next cycle; one per cycle unless the output stalls.
// Reseed: fills all sixteen pool words (one seed multiplier, one word a cycle), no result.
// Reset: the same fill runs with a zero seed; input not ready meanwhile.
// The ring rotates on each generate so the current position always sits at cell 0.
`include "well512_random_generator_core_assert.svh"
module well512_random_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
  input  logic [0:0]  s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] random_word
);

  w512_pkg::word_t  words   [w512_pkg::PoolDepth];
  w512_pkg::word_t  from_lo [w512_pkg::PoolDepth];
  w512_pkg::word_t  from_hi [w512_pkg::PoolDepth];
  w512_pkg::shift_t shift;
  w512_pkg::word_t  fresh;
  w512_pkg::word_t  out_word;
  w512_pkg::word_t  seed_word;
  logic             seed_busy;
  logic             in_xfer;
  logic             gen_xfer;
  logic             reseed_xfer;
  logic             out_valid_q;
  w512_pkg::word_t  out_data_q;

  assign s_axis_tready = !seed_busy && (!out_valid_q || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign gen_xfer      = in_xfer && !s_axis_tuser[0];
  assign reseed_xfer   = in_xfer && s_axis_tuser[0];

  assign shift.gen  = gen_xfer;
  assign shift.fill = seed_busy;

  w512_seed u_seed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (reseed_xfer),
    .seed_i  (s_axis_tdata),
    .busy_o  (seed_busy),
    .value_o (seed_word)
  );

  w512_mix u_mix (
    .x_i     (words[0]),
    .y_i     (words[w512_pkg::TapY]),
    .z_i     (words[w512_pkg::TapZ]),
    .prev_i  (words[w512_pkg::TapPrev]),
    .fresh_o (fresh),
    .out_o   (out_word)
  );

  // On generate the new position is one below, so every word moves up one cell;
  // the two rewritten words land in cells 0 and 1. A fill shifts words down from cell 15.
  for (genvar k = 0; k < w512_pkg::PoolDepth; k++) begin : g_cell
    if (k == 0) begin : g_lo_out
      assign from_lo[k] = out_word;
    end else if (k == 1) begin : g_lo_fresh
      assign from_lo[k] = fresh;
    end else begin : g_lo_ring
      assign from_lo[k] = words[k-1];
    end

    if (k == w512_pkg::PoolDepth - 1) begin : g_hi_seed
      assign from_hi[k] = seed_word;
    end else begin : g_hi_ring
      assign from_hi[k] = words[k+1];
    end

    w512_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (shift),
      .from_lo_i (from_lo[k]),
      .from_hi_i (from_hi[k]),
      .word_o    (words[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (gen_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_xfer) begin
      out_data_q <= out_word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `W512_ASSERT_NEXT(a_gen_gives_result, gen_xfer, m_axis_tvalid, "generate transfer gave no result")
  `W512_ASSERT_NEXT(a_reseed_starts_fill, reseed_xfer, seed_busy && !s_axis_tready, "reseed did not start the pool fill")
  `W512_ASSERT(a_no_gen_on_stall, (m_axis_tvalid && !m_axis_tready) |-> !gen_xfer, "generate taken while result stalled")

endmodule
